>>> hw/rtl/mdp_pkg.sv
// Shared types and constants of the MoldUDP64 packet deframer.
`default_nettype none

package mdp_pkg;

   localparam int SESSION_BYTES = 10;
   localparam int SEQ_BYTES     = 8;
   localparam int HEADER_BYTES  = 10 + 8 + 2;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [2:0] KIND_SESSION   = 3'd0;
   localparam logic [2:0] KIND_HDR_DONE  = 3'd1;
   localparam logic [2:0] KIND_MSG_START = 3'd2;
   localparam logic [2:0] KIND_PAYLOAD   = 3'd3;
   localparam logic [2:0] KIND_ERROR     = 3'd4;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_SHORT_HDR = 2'd1;
   localparam logic [1:0] ERR_TRUNCATED = 2'd2;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       end_of_packet;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  data_byte;
      logic [15:0] byte_index;
      logic [15:0] message_index;
      logic [15:0] message_length;
      logic [63:0] seq_num;
      logic [15:0] msg_total;
      logic        last_of_message;
      logic [1:0]  error_code;
      logic        last_result;
   } rsp_type;

   // Write strobes from the parser into the result queue.
   typedef struct packed {
      logic push0;
      logic push1;
   } push_type;

endpackage

`default_nettype wire

>>> hw/rtl/mdp_parser.sv
// Header and message block parser: packet state and per-byte result generation.
`default_nettype none

module mdp_parser (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire mdp_pkg::req_type req,
   output mdp_pkg::push_type     push,
   output mdp_pkg::rsp_type      slot0,
   output mdp_pkg::rsp_type      slot1
);
   import mdp_pkg::*;

   localparam logic [2:0] PH_HEADER  = 3'd0;
   localparam logic [2:0] PH_LEN_HI  = 3'd1;
   localparam logic [2:0] PH_LEN_LO  = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_SKIP    = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic [4:0]  hdr_pos_ff, hdr_pos_in;
   logic [63:0] seq_ff, seq_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] pay_pos_ff, pay_pos_in;
   logic [15:0] msg_ff, msg_in;

   logic        prim_valid;
   rsp_type     prim;
   rsp_type     err_rsp;
   logic [1:0]  err_code;
   logic [15:0] left_dec;
   logic [15:0] new_len;
   logic [15:0] new_count;
   logic        last_byte;
   logic [7:0]  b;

   assign b         = req.byte_in;
   assign left_dec  = left_ff - 16'd1;
   assign new_len   = {len_ff[15:8], b};
   assign new_count = {count_ff[7:0], b};
   assign last_byte = ({1'b0, pay_pos_ff} + 17'd1) >= {1'b0, len_ff};

   always_comb begin
      phase_in   = phase_ff;
      hdr_pos_in = hdr_pos_ff;
      seq_in     = seq_ff;
      count_in   = count_ff;
      left_in    = left_ff;
      len_in     = len_ff;
      pay_pos_in = pay_pos_ff;
      msg_in     = msg_ff;
      prim_valid = 1'b0;
      prim       = '0;
      err_code   = ERR_NONE;

      unique case (phase_ff)
         PH_HEADER: begin
            if (hdr_pos_ff < 5'(SESSION_BYTES)) begin
               prim_valid      = 1'b1;
               prim.kind       = KIND_SESSION;
               prim.data_byte  = b;
               prim.byte_index = {11'd0, hdr_pos_ff};
            end else if (hdr_pos_ff < 5'(SESSION_BYTES + SEQ_BYTES)) begin
               seq_in = {seq_ff[55:0], b};
            end else begin
               count_in = new_count;
            end
            if (hdr_pos_ff >= 5'(HEADER_BYTES - 1)) begin
               prim_valid     = 1'b1;
               prim.kind      = KIND_HDR_DONE;
               prim.seq_num   = seq_ff;
               prim.msg_total = new_count;
               left_in        = new_count;
               msg_in         = '0;
               phase_in       = (new_count != 16'd0) ? PH_LEN_HI : PH_SKIP;
            end else begin
               hdr_pos_in = hdr_pos_ff + 5'd1;
               if (req.end_of_packet) err_code = ERR_SHORT_HDR;
            end
         end
         PH_LEN_HI: begin
            len_in   = {b, 8'd0};
            phase_in = PH_LEN_LO;
            if (req.end_of_packet) err_code = ERR_TRUNCATED;
         end
         PH_LEN_LO: begin
            len_in              = new_len;
            prim_valid          = 1'b1;
            prim.kind           = KIND_MSG_START;
            prim.message_index  = msg_ff;
            prim.message_length = new_len;
            prim.seq_num        = seq_ff;
            prim.msg_total      = count_ff;
            if (new_len == 16'd0) begin
               left_in  = left_dec;
               msg_in   = msg_ff + 16'd1;
               phase_in = (left_dec != 16'd0) ? PH_LEN_HI : PH_SKIP;
            end else begin
               pay_pos_in = '0;
               phase_in   = PH_PAYLOAD;
               if (req.end_of_packet) err_code = ERR_TRUNCATED;
            end
         end
         PH_PAYLOAD: begin
            prim_valid           = 1'b1;
            prim.kind            = KIND_PAYLOAD;
            prim.data_byte       = b;
            prim.byte_index      = pay_pos_ff;
            prim.message_index   = msg_ff;
            prim.message_length  = len_ff;
            prim.seq_num         = seq_ff;
            prim.msg_total       = count_ff;
            prim.last_of_message = last_byte;
            if (last_byte) begin
               left_in  = left_dec;
               msg_in   = msg_ff + 16'd1;
               phase_in = (left_dec != 16'd0) ? PH_LEN_HI : PH_SKIP;
            end else begin
               pay_pos_in = pay_pos_ff + 16'd1;
               if (req.end_of_packet) err_code = ERR_TRUNCATED;
            end
         end
         default: begin
            // skip phase and unused codes: ignore the byte
         end
      endcase

      // the end of a packet always returns to the header phase
      if (req.end_of_packet) begin
         phase_in   = PH_HEADER;
         hdr_pos_in = '0;
         seq_in     = '0;
         count_in   = '0;
         left_in    = '0;
         len_in     = '0;
         pay_pos_in = '0;
         msg_in     = '0;
      end
   end

   always_comb begin
      err_rsp            = '0;
      err_rsp.kind       = KIND_ERROR;
      err_rsp.error_code = err_code;
      if (err_code == ERR_TRUNCATED) begin
         err_rsp.message_index = msg_ff;
         err_rsp.seq_num       = seq_ff;
         err_rsp.msg_total     = count_ff;
      end
      err_rsp.last_result = 1'b1;

      slot0             = prim_valid ? prim : err_rsp;
      slot0.last_result = !(prim_valid && (err_code != ERR_NONE));
      slot1             = err_rsp;

      push.push0 = accept && (prim_valid || (err_code != ERR_NONE));
      push.push1 = accept && prim_valid && (err_code != ERR_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_pos_ff <= '0;
         seq_ff     <= '0;
         count_ff   <= '0;
         left_ff    <= '0;
         len_ff     <= '0;
         pay_pos_ff <= '0;
         msg_ff     <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         hdr_pos_ff <= hdr_pos_in;
         seq_ff     <= seq_in;
         count_ff   <= count_in;
         left_ff    <= left_in;
         len_ff     <= len_in;
         pay_pos_ff <= pay_pos_in;
         msg_ff     <= msg_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/mdp_rsp_queue.sv
// Result queue: takes up to two results a cycle, hands out one a cycle while rsp_stall is low.
`default_nettype none

module mdp_rsp_queue #(
   parameter int DEPTH = mdp_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mdp_pkg::push_type push,
   input  wire mdp_pkg::rsp_type  slot0,
   input  wire mdp_pkg::rsp_type  slot1,
   output logic                   room,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output mdp_pkg::rsp_type       rsp_payload
);
   import mdp_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rsp_type         q_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [AW-1:0]   wr_next;
   logic            pop;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   assign wr_next     = wrap_inc(wr_ptr_ff);
   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = q_ff[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;
   assign room        = (count_ff <= CW'(DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.push1) wr_ptr_in = wrap_inc(wr_next);
      else if (push.push0) wr_ptr_in = wr_next;
      rd_ptr_in = pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push.push0) + CW'(push.push1) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.push0) q_ff[wr_ptr_ff] <= slot0;
      if (push.push1) q_ff[wr_next] <= slot1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push.push1 |-> push.push0)
      else $error("second result written without the first");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.push0 |-> (count_ff <= CW'(DEPTH - 1)))
      else $error("result written into a full queue");

   a_pair_room: assert property (@(posedge clock) disable iff (reset)
      push.push1 |-> (count_ff <= CW'(DEPTH - 2)))
      else $error("result pair written without room for both");

   a_pair_last: assert property (@(posedge clock) disable iff (reset)
      push.push1 |-> (slot1.last_result && !slot0.last_result))
      else $error("last-result flag on the wrong slot of a pair");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (push.push0 && !push.push1) |-> slot0.last_result)
      else $error("single result not flagged as last");

endmodule

`default_nettype wire

>>> hw/rtl/moldudp64_packet_deframer.sv
// Top level of the MoldUDP64 packet deframer.
`default_nettype none

// Takes one packet byte per cycle and turns it into zero, one or two result
// transfers (session byte, header done, message start, payload byte, packet
// error). The parser updates its packet state in the cycle a byte is
// accepted and writes the results of that byte into a QUEUE_DEPTH-entry
// result queue, which registers them before rsp_valid shows them. Results
// leave at one per cycle while rsp_stall is low; req_stall rises while fewer
// than two queue entries are free, so a byte can be accepted every cycle as
// long as the sustained number of results does not exceed one per byte and
// the result side keeps taking them. QUEUE_DEPTH must be at least 2.
module moldudp64_packet_deframer #(
   parameter int QUEUE_DEPTH = mdp_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire mdp_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output mdp_pkg::rsp_type      rsp_payload
);
   import mdp_pkg::*;

   push_type push;
   rsp_type  slot0;
   rsp_type  slot1;
   logic     room;
   logic     accept;

   assign req_stall = !room;
   assign accept    = req_valid && room;

   mdp_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .push   (push),
      .slot0  (slot0),
      .slot1  (slot1)
   );

   mdp_rsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .slot0       (slot0),
      .slot1       (slot1),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
